[rtl/core/rmf_pkg.sv]
package rmf_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_WINDOW = 15;

  localparam int PIX_BITS  = 8;
  localparam int CH_COUNT  = 3;
  localparam int DIM_BITS  = 11;
  localparam int REACH_BITS = 3;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [DIM_BITS-1:0]   RST_WIDTH  = 11'd640;
  localparam logic [DIM_BITS-1:0]   RST_HEIGHT = 11'd480;
  localparam logic [REACH_BITS-1:0] RST_REACH  = 3'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_REACH  = 2'd2;

  // pass 0 counts the window, passes 1..PIX_BITS resolve one bit each
  localparam logic [3:0] LAST_PASS = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_STEP,
    ST_OUT
  } state_t;

endpackage

[rtl/core/rmf_ram.sv]
module rmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/rmf_win_scan.sv]
module rmf_win_scan #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_WINDOW = 15
) (
  input  logic                                                clk,
  input  logic                                                load,
  input  logic                                                advance,
  input  logic [$clog2(MAX_WINDOW*MAX_WIDTH)-1:0]             base,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]                     row,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]                      col,
  input  logic [rmf_pkg::REACH_BITS-1:0]                      reach,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]                      w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]                     h,
  input  logic [$clog2(MAX_WINDOW*MAX_WIDTH)-1:0]             rowstep,
  output logic [$clog2(MAX_WINDOW*MAX_WIDTH)-1:0]             addr,
  output logic                                                inframe,
  output logic                                                last
);
  import rmf_pkg::*;

  localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int AW = $clog2(DEPTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int SW = ((WW > HW) ? WW : HW) + 1;
  localparam int KW = $clog2(MAX_WINDOW + 1);

  logic [AW-1:0]        idx;
  logic signed [SW-1:0] ii;
  logic signed [SW-1:0] jj;
  logic [KW-1:0]        di;
  logic [KW-1:0]        dj;
  logic [KW-1:0]        span;
  logic signed [SW-1:0] r_s;
  logic signed [SW-1:0] h_s;
  logic signed [SW-1:0] w_s;
  logic signed [SW-1:0] col_start;
  logic [AW:0]          row_sum;
  logic [AW-1:0]        idx_col;
  logic [AW-1:0]        idx_row;

  assign span = KW'({reach, 1'b0});
  assign r_s = signed'(SW'(reach));
  assign h_s = signed'(SW'(h));
  assign w_s = signed'(SW'(w));
  assign col_start = signed'(SW'(col)) - r_s;

  assign idx_col = (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
  assign row_sum = {1'b0, idx} + {1'b0, rowstep};
  assign idx_row = (row_sum >= (AW+1)'(DEPTH)) ? AW'(row_sum - (AW+1)'(DEPTH))
                                               : row_sum[AW-1:0];

  assign addr = idx;
  assign last = (di == span) && (dj == span);
  assign inframe = (ii >= 0) && (ii < h_s) && (jj >= 0) && (jj < w_s);

  always_ff @(posedge clk) begin
    if (load) begin
      idx <= base;
      ii  <= signed'(SW'(row)) - r_s;
      jj  <= col_start;
      di  <= '0;
      dj  <= '0;
    end else if (advance) begin
      if (dj == span) begin
        dj  <= '0;
        jj  <= col_start;
        di  <= di + KW'(1);
        ii  <= ii + SW'(1);
        idx <= idx_row;
      end else begin
        dj  <= dj + KW'(1);
        jj  <= jj + SW'(1);
        idx <= idx_col;
      end
    end
  end

endmodule

[rtl/core/rmf_bit_select.sv]
module rmf_bit_select #(
  parameter int MAX_WINDOW = 15
) (
  input  logic                                           clk,
  input  logic                                           start,
  input  logic                                           acc,
  input  logic [rmf_pkg::CH_COUNT*rmf_pkg::PIX_BITS-1:0] data,
  input  logic                                           decide,
  input  logic                                           count_pass,
  output logic [rmf_pkg::CH_COUNT*rmf_pkg::PIX_BITS-1:0] median
);
  import rmf_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW * MAX_WINDOW + 1);

  logic [CW-1:0]       cnt;
  logic [CW-1:0]       c0   [CH_COUNT];
  logic [CW-1:0]       rank [CH_COUNT];
  logic [PIX_BITS-1:0] pref [CH_COUNT];
  logic [PIX_BITS-1:0] bm;
  logic [PIX_BITS-1:0] hm;
  logic [CH_COUNT-1:0] match;

  // a value counts when it agrees with the resolved upper bits and has a zero here
  always_comb begin
    for (int c = 0; c < CH_COUNT; c++) begin
      match[c] = (((data[c*PIX_BITS +: PIX_BITS] ^ pref[c]) & hm) == '0) &&
                 ((data[c*PIX_BITS +: PIX_BITS] & bm) == '0);
      median[c*PIX_BITS +: PIX_BITS] = pref[c];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      for (int c = 0; c < CH_COUNT; c++) c0[c] <= '0;
    end else if (acc) begin
      if (count_pass) begin
        cnt <= cnt + CW'(1);
      end else begin
        for (int c = 0; c < CH_COUNT; c++) c0[c] <= c0[c] + CW'(match[c]);
      end
    end else if (decide) begin
      for (int c = 0; c < CH_COUNT; c++) c0[c] <= '0;
      if (count_pass) begin
        for (int c = 0; c < CH_COUNT; c++) begin
          rank[c] <= cnt >> 1;
          pref[c] <= '0;
        end
        bm <= {1'b1, {(PIX_BITS-1){1'b0}}};
        hm <= '0;
      end else begin
        for (int c = 0; c < CH_COUNT; c++) begin
          if (rank[c] >= c0[c]) begin
            pref[c] <= pref[c] | bm;
            rank[c] <= rank[c] - c0[c];
          end
        end
        bm <= bm >> 1;
        hm <= {1'b1, hm[PIX_BITS-1:1]};
      end
    end
  end

endmodule

[rtl/core/rgb_median_filter_2d_top.sv]
// result: an item that completes a window raises m_tvalid after nine sweeps of scan, drain and step;
// other items raise no output
// flow: one item at a time, set by the single line store read port that is swept once for
// the count and once per result bit; the next request is taken once the FSM is back in idle
// reset: synchronous, clears counters and control, loads default frame registers;
// the line store is not cleared
module rgb_median_filter_2d_top #(
  parameter int MAX_WIDTH  = rmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rmf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WINDOW = rmf_pkg::DEF_MAX_WINDOW
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [23:0]                          s_tdata,  // in_red, in_green, in_blue
  input  logic                                 s_tuser,  // req_type
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [23:0]                          m_tdata,  // out_red, out_green, out_blue
  output logic                                 m_tuser,  // frame_done
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rmf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [rmf_pkg::DIM_BITS-1:0]         cfg_data
);
  import rmf_pkg::*;

  localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int AW = $clog2(DEPTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int TW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int NW = TW + 1;
  localparam int RMAX = (MAX_WINDOW - 1) / 2;
  localparam int LW = $clog2(RMAX * MAX_WIDTH + RMAX + 1);
  localparam int PW = CH_COUNT * PIX_BITS;

  state_t state, state_next;

  logic [DIM_BITS-1:0]   cfg_width;
  logic [DIM_BITS-1:0]   cfg_height;
  logic [REACH_BITS-1:0] cfg_reach;
  logic                  cfg_fresh;

  logic [WW-1:0]         w_c, w_eff;
  logic [HW-1:0]         h_c, h_eff;
  logic [REACH_BITS-1:0] r_c, r_eff;
  logic [TW-1:0]         total;
  logic [LW-1:0]         lag;
  logic [AW-1:0]         rowstep;
  logic [AW:0]           rowstep_raw;

  logic [NW-1:0] incnt;
  logic [TW-1:0] outcnt;
  logic [AW-1:0] wmod;
  logic [AW-1:0] kmod;
  logic [HW-1:0] row;
  logic [WW-1:0] col;
  logic [3:0]    pass;
  logic          rd_vld;

  logic          take;
  logic          cfg_take;
  logic          produce;
  logic          frame_done;
  logic [AW-1:0] base;
  logic [AW-1:0] wmod_inc;
  logic [AW-1:0] kmod_inc;

  logic          scan_load;
  logic          scan_adv;
  logic          sel_start;
  logic          sel_decide;
  logic          out_load;

  logic [AW-1:0] rd_addr;
  logic [PW-1:0] rd_data;
  logic          inframe;
  logic          scan_last;
  logic [PW-1:0] median;

  // effective geometry, registered once per cycle from the frame registers
  always_comb begin
    if (cfg_width == '0) w_c = WW'(1);
    else if (32'(cfg_width) > MAX_WIDTH) w_c = WW'(MAX_WIDTH);
    else w_c = WW'(cfg_width);
    if (cfg_height == '0) h_c = HW'(1);
    else if (32'(cfg_height) > MAX_HEIGHT) h_c = HW'(MAX_HEIGHT);
    else h_c = HW'(cfg_height);
    r_c = (32'(cfg_reach) > RMAX) ? REACH_BITS'(RMAX) : cfg_reach;
    rowstep_raw = (AW+1)'(w_c) + (AW+1)'(DEPTH) - (AW+1)'({r_c, 1'b0});
  end

  always_ff @(posedge clk) begin
    w_eff   <= w_c;
    h_eff   <= h_c;
    r_eff   <= r_c;
    total   <= TW'(w_c) * TW'(h_c);
    lag     <= LW'(r_c) * LW'(w_c) + LW'(r_c);
    rowstep <= (rowstep_raw >= (AW+1)'(DEPTH)) ? AW'(rowstep_raw - (AW+1)'(DEPTH))
                                               : rowstep_raw[AW-1:0];
  end

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;
  // a register write has priority over a pixel request in the same cycle
  assign s_tready  = (state == ST_IDLE) && !cfg_fresh && !cfg_valid;
  assign take      = s_tvalid && s_tready;
  assign produce   = (incnt >= NW'(lag)) && (outcnt < total);
  assign frame_done = ((TW+1)'(outcnt) + (TW+1)'(1)) >= (TW+1)'(total);
  assign base = (kmod >= AW'(lag)) ? kmod - AW'(lag)
                                   : AW'((AW+1)'(kmod) + (AW+1)'(DEPTH) - (AW+1)'(lag));
  assign wmod_inc = (wmod == AW'(DEPTH - 1)) ? '0 : wmod + AW'(1);
  assign kmod_inc = (kmod == AW'(DEPTH - 1)) ? '0 : kmod + AW'(1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (take && produce) state_next = ST_RUN;
      ST_RUN:   if (scan_last) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_STEP;
      ST_STEP:  state_next = (pass == LAST_PASS) ? ST_OUT : ST_RUN;
      ST_OUT:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    scan_load  = 1'b0;
    scan_adv   = 1'b0;
    sel_start  = 1'b0;
    sel_decide = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        scan_load = take;
        sel_start = take;
      end
      ST_RUN:   scan_adv = 1'b1;
      ST_DRAIN: ;
      ST_STEP: begin
        sel_decide = 1'b1;
        scan_load  = (pass != LAST_PASS);
      end
      ST_OUT:   out_load = !m_tvalid || m_tready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cfg_width  <= RST_WIDTH;
      cfg_height <= RST_HEIGHT;
      cfg_reach  <= RST_REACH;
      cfg_fresh  <= 1'b1;
      incnt      <= '0;
      outcnt     <= '0;
      wmod       <= '0;
      kmod       <= '0;
      row        <= '0;
      col        <= '0;
      pass       <= '0;
      rd_vld     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state     <= state_next;
      cfg_fresh <= 1'b0;
      rd_vld    <= (state == ST_RUN) && inframe;

      if (cfg_take && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                       cfg_index == REG_REACH)) begin
        case (cfg_index)
          REG_WIDTH:  cfg_width  <= cfg_data;
          REG_HEIGHT: cfg_height <= cfg_data;
          REG_REACH:  cfg_reach  <= cfg_data[REACH_BITS-1:0];
          default:    ;
        endcase
        // new geometry restarts the frame
        cfg_fresh <= 1'b1;
        incnt     <= '0;
        outcnt    <= '0;
        wmod      <= '0;
        kmod      <= '0;
        row       <= '0;
        col       <= '0;
      end

      if (take) begin
        pass <= '0;
        if (incnt < NW'(total)) wmod <= wmod_inc;
        if (incnt != '1) incnt <= incnt + NW'(1);
      end

      if (sel_decide) pass <= pass + 4'd1;

      if (out_load) begin
        m_tvalid <= 1'b1;
        if (frame_done) begin
          incnt  <= '0;
          outcnt <= '0;
          wmod   <= '0;
          kmod   <= '0;
          row    <= '0;
          col    <= '0;
        end else begin
          outcnt <= outcnt + TW'(1);
          kmod   <= kmod_inc;
          if (col == w_eff - WW'(1)) begin
            col <= '0;
            row <= row + HW'(1);
          end else begin
            col <= col + WW'(1);
          end
        end
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= median;
      m_tuser <= frame_done;
    end
  end

  rmf_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (take && (incnt < NW'(total))),
    .wr_addr (wmod),
    .wr_data (s_tuser ? '0 : s_tdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rmf_win_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_scan (
    .clk     (clk),
    .load    (scan_load),
    .advance (scan_adv),
    .base    (base),
    .row     (row),
    .col     (col),
    .reach   (r_eff),
    .w       (w_eff),
    .h       (h_eff),
    .rowstep (rowstep),
    .addr    (rd_addr),
    .inframe (inframe),
    .last    (scan_last)
  );

  rmf_bit_select #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_select (
    .clk        (clk),
    .start      (sel_start),
    .acc        (rd_vld),
    .data       (rd_data),
    .decide     (sel_decide),
    .count_pass (pass == '0),
    .median     (median)
  );

endmodule
